>>> rtl/core/trm_pkg.sv
// trm_pkg: widths, channel codes and payload types of the trimmed-mean averager
// used by the interfaces, the window datapath and the top level
package trm_pkg;

   localparam int SampleWidth  = 12;
   localparam int ChanWidth    = 5;
   localparam int SlotOutWidth = 3;
   localparam int CountWidth   = 3;
   localparam int SumWidth     = 15;

   localparam logic [CountWidth-1:0]  Window    = CountWidth'(6);
   localparam logic [SampleWidth-1:0] SampleMax = 12'hFFF;

   // transaction kinds
   localparam logic KindSample = 1'b0;
   localparam logic KindRead   = 1'b1;

   // ADC channel codes of slots 0, 1 and 2
   localparam logic [ChanWidth-1:0] ChanSlot0 = 5'd12;
   localparam logic [ChanWidth-1:0] ChanSlot1 = 5'd14;
   localparam logic [ChanWidth-1:0] ChanSlot2 = 5'd8;

   typedef struct packed {
      logic                     kind;
      logic [SampleWidth-1:0]   sample;
      logic [ChanWidth-1:0]     query_channel;
   } req_payload_type;

   typedef struct packed {
      logic [SlotOutWidth-1:0]  next_slot;
      logic                     window_done;
      logic [SlotOutWidth-1:0]  done_slot;
      logic [SampleWidth-1:0]   done_average;
      logic [SampleWidth-1:0]   read_value;
   } rsp_payload_type;

endpackage

>>> rtl/core/trm_if.sv
// trm_req_if / trm_rsp_if: valid/ready channels of the trimmed-mean averager
// depends on trm_pkg for field widths
interface trm_req_if
   import trm_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [SampleWidth-1:0] sample;
   logic [ChanWidth-1:0]   query_channel;

   modport source (output valid, output kind, output sample, output query_channel,
                   input ready);
   modport sink   (input valid, input kind, input sample, input query_channel,
                   output ready);
endinterface

interface trm_rsp_if
   import trm_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [SlotOutWidth-1:0] next_slot;
   logic                    window_done;
   logic [SlotOutWidth-1:0] done_slot;
   logic [SampleWidth-1:0]  done_average;
   logic [SampleWidth-1:0]  read_value;

   modport source (output valid, output next_slot, output window_done,
                   output done_slot, output done_average, output read_value,
                   input ready);
   modport sink   (input valid, input next_slot, input window_done,
                   input done_slot, input done_average, input read_value,
                   output ready);
endinterface

>>> rtl/core/round_robin_trimmed_mean_adc.sv
// an accepted request enters the input register, its response the output register
// throughput: one transaction per cycle unless a response stalls; input register feeds
//   the window datapath, whose output register can hold while the input side moves
// reset (synchronous, active high): both stages empty, slot 0, empty window,
//   all stored averages zero
module round_robin_trimmed_mean_adc
   import trm_pkg::*;
#(
   parameter int SLOTS = 3
) (
   input  logic          clock,
   input  logic          reset,
   trm_req_if.sink       req_bus,
   trm_rsp_if.source     rsp_bus
);

   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_item_ff, s1_item_in;
   logic            s2_valid_ff, s2_valid_in;
   rsp_payload_type s2_rsp_ff, s2_rsp_in;
   rsp_payload_type result;
   logic            s1_move;
   logic            req_take;

   trm_window #(.SLOTS(SLOTS)) u_window (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_move),
      .item    (s1_item_ff),
      .result  (result)
   );

   always_comb begin
      s1_move       = s1_valid_ff && (!s2_valid_ff || rsp_bus.ready);
      req_bus.ready = !s1_valid_ff || s1_move;
      req_take      = req_bus.valid && req_bus.ready;

      s1_valid_in = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s1_item_in  = s1_item_ff;
      if (req_take) begin
         s1_item_in.kind          = req_bus.kind;
         s1_item_in.sample        = req_bus.sample;
         s1_item_in.query_channel = req_bus.query_channel;
      end

      s2_valid_in = s1_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : s2_valid_ff);
      s2_rsp_in   = s1_move ? result : s2_rsp_ff;

      rsp_bus.valid        = s2_valid_ff;
      rsp_bus.next_slot    = s2_rsp_ff.next_slot;
      rsp_bus.window_done  = s2_rsp_ff.window_done;
      rsp_bus.done_slot    = s2_rsp_ff.done_slot;
      rsp_bus.done_average = s2_rsp_ff.done_average;
      rsp_bus.read_value   = s2_rsp_ff.read_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      s2_rsp_ff  <= s2_rsp_in;
   end

endmodule

>>> rtl/core/trm_window.sv
// trm_window: running max/min/sum per window, slot rotation and stored averages
// computes one transaction's result and commits state on step_en; uses trm_pkg
module trm_window
   import trm_pkg::*;
#(
   parameter int SLOTS = 3
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  req_payload_type item,
   output rsp_payload_type result
);

   localparam int SlotBits = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SlotBits-1:0] LastSlot = SlotBits'(SLOTS - 1);

   logic [SlotBits-1:0]    slot_ff, slot_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [SampleWidth-1:0] max_ff, max_in;
   logic [SampleWidth-1:0] min_ff, min_in;
   logic [SumWidth-1:0]    sum_ff, sum_in;
   logic [SampleWidth-1:0] avg_ff [SLOTS];
   logic [SampleWidth-1:0] avg_in [SLOTS];

   logic                    is_sample;
   logic [SampleWidth-1:0]  max_new, min_new;
   logic [SumWidth-1:0]     sum_new, trimmed;
   logic [CountWidth-1:0]   count_new;
   logic                    win_done;
   logic [SampleWidth-1:0]  avg_new;
   logic [SlotBits-1:0]     slot_inc;
   logic                    q_known;
   logic [SlotOutWidth-1:0] q_slot;
   logic [SampleWidth-1:0]  rd_value;

   always_comb begin
      is_sample = (item.kind == KindSample);
      max_new   = (item.sample > max_ff) ? item.sample : max_ff;
      min_new   = (item.sample < min_ff) ? item.sample : min_ff;
      sum_new   = sum_ff + SumWidth'(item.sample);
      count_new = count_ff + CountWidth'(1);
      win_done  = is_sample && (count_new == Window);
      // drop largest and smallest, then divide the four left by 4
      trimmed   = sum_new - SumWidth'(max_new) - SumWidth'(min_new);
      avg_new   = trimmed[SampleWidth+1:2];
      slot_inc  = (slot_ff == LastSlot) ? '0 : slot_ff + SlotBits'(1);

      case (item.query_channel)
         ChanSlot0: begin
            q_known = 1'b1;
            q_slot  = SlotOutWidth'(0);
         end
         ChanSlot1: begin
            q_known = 1'b1;
            q_slot  = SlotOutWidth'(1);
         end
         ChanSlot2: begin
            q_known = 1'b1;
            q_slot  = SlotOutWidth'(2);
         end
         default: begin
            q_known = 1'b0;
            q_slot  = '0;
         end
      endcase

      // slots at or beyond SLOTS match no entry and read as zero
      rd_value = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (q_known && q_slot == SlotOutWidth'(i)) begin
            rd_value = avg_ff[i];
         end
      end

      slot_in  = slot_ff;
      count_in = count_ff;
      max_in   = max_ff;
      min_in   = min_ff;
      sum_in   = sum_ff;
      for (int i = 0; i < SLOTS; i++) begin
         avg_in[i] = avg_ff[i];
      end
      if (step_en && is_sample) begin
         if (win_done) begin
            count_in = '0;
            max_in   = '0;
            min_in   = SampleMax;
            sum_in   = '0;
            slot_in  = slot_inc;
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_ff == SlotBits'(i)) begin
                  avg_in[i] = avg_new;
               end
            end
         end else begin
            count_in = count_new;
            max_in   = max_new;
            min_in   = min_new;
            sum_in   = sum_new;
         end
      end

      result.next_slot    = SlotOutWidth'(win_done ? slot_inc : slot_ff);
      result.window_done  = win_done;
      result.done_slot    = win_done ? SlotOutWidth'(slot_ff) : '0;
      result.done_average = win_done ? avg_new : '0;
      result.read_value   = is_sample ? '0 : rd_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         max_ff   <= '0;
         min_ff   <= SampleMax;
         sum_ff   <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            avg_ff[i] <= '0;
         end
      end else begin
         slot_ff  <= slot_in;
         count_ff <= count_in;
         max_ff   <= max_in;
         min_ff   <= min_in;
         sum_ff   <= sum_in;
         for (int i = 0; i < SLOTS; i++) begin
            avg_ff[i] <= avg_in[i];
         end
      end
   end

endmodule

>>> rtl/core/trm_checker.sv
// trm_checker: port-level checks of the trimmed-mean averager, bound to the top level
// depends on trm_pkg and round_robin_trimmed_mean_adc
module trm_checker
   import trm_pkg::*;
#(
   parameter int SLOTS = 3
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SlotOutWidth-1:0] rsp_next_slot,
   input logic                    rsp_window_done,
   input logic [SlotOutWidth-1:0] rsp_done_slot,
   input logic [SampleWidth-1:0]  rsp_done_average,
   input logic [SampleWidth-1:0]  rsp_read_value
);

   localparam logic [SlotOutWidth-1:0] LastSlot = SlotOutWidth'(SLOTS - 1);

   // a stalled response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_done_average)
         && $stable(rsp_read_value) && $stable(rsp_next_slot))
      else $error("response changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_window_done |-> rsp_done_slot == '0 && rsp_done_average == '0)
      else $error("done fields set without a finished window");

   a_no_read_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window_done |-> rsp_read_value == '0)
      else $error("read value on a sample transaction");

   // round robin: the slot after a finished window follows the one just done
   a_rotation: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_window_done |->
         ((rsp_done_slot == LastSlot && rsp_next_slot == '0)
          || (rsp_done_slot != LastSlot && rsp_next_slot == rsp_done_slot + 3'd1)))
      else $error("slot rotation broken");

endmodule

bind round_robin_trimmed_mean_adc trm_checker #(.SLOTS(SLOTS)) u_trm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_next_slot    (rsp_bus.next_slot),
   .rsp_window_done  (rsp_bus.window_done),
   .rsp_done_slot    (rsp_bus.done_slot),
   .rsp_done_average (rsp_bus.done_average),
   .rsp_read_value   (rsp_bus.read_value)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for round_robin_trimmed_mean_adc
// depends on trm_pkg and the trm_req_if / trm_rsp_if interfaces
module tb_top;
   import trm_pkg::*;

   localparam int SLOTS = 3;
   localparam int SlotIdxBits = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SlotOutWidth-1:0] LastSlot = SlotOutWidth'(SLOTS - 1);

   logic clock;
   logic reset;

   trm_req_if req_bus ();
   trm_rsp_if rsp_bus ();

   round_robin_trimmed_mean_adc #(.SLOTS(SLOTS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   req_payload_type stimulus_q[$];
   rsp_payload_type expected_avg_q[$];

   int  mismatch_count = 0;
   int  accepted_count = 0;
   int  hold_left      = 0;
   bit  hold_done      = 1'b0;
   logic req_taken     = 1'b0;

   // predicted state of the averager
   logic [SlotOutWidth-1:0] slot_now;
   logic [CountWidth-1:0]   win_count;
   logic [SampleWidth-1:0]  win_max;
   logic [SampleWidth-1:0]  win_min;
   logic [SumWidth-1:0]     win_sum;
   logic [SampleWidth-1:0]  slot_avg[SLOTS];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic rsp_payload_type trimmed_mean_step(input req_payload_type t);
      rsp_payload_type     r;
      logic [SumWidth-1:0] trimmed;
      r = '0;
      if (t.kind == KindRead) begin
         case (t.query_channel)
            ChanSlot0: r.read_value = slot_avg[0];
            ChanSlot1: r.read_value = slot_avg[1];
            ChanSlot2: r.read_value = slot_avg[2];
            default:   r.read_value = '0;
         endcase
      end else begin
         if (t.sample > win_max) win_max = t.sample;
         if (t.sample < win_min) win_min = t.sample;
         win_sum   = win_sum + SumWidth'(t.sample);
         win_count = win_count + CountWidth'(1);
         if (win_count >= Window) begin
            // drop largest and smallest, mean of the remaining four
            trimmed = win_sum - SumWidth'(win_max) - SumWidth'(win_min);
            r.window_done  = 1'b1;
            r.done_slot    = slot_now;
            r.done_average = trimmed[13:2];
            slot_avg[slot_now[SlotIdxBits-1:0]] = trimmed[13:2];
            win_count = '0;
            win_max   = '0;
            win_min   = SampleMax;
            win_sum   = '0;
            slot_now  = (slot_now == LastSlot) ? '0 : slot_now + SlotOutWidth'(1);
         end
      end
      r.next_slot = slot_now;
      return r;
   endfunction

   function automatic int idle_pct(input bit receiver);
      if (accepted_count < 250) return receiver ? 83 : 18;
      if (accepted_count < 500) return receiver ? 18 : 83;
      return 0;
   endfunction

   task automatic add_sample(input logic [SampleWidth-1:0] value);
      req_payload_type t;
      t.kind          = KindSample;
      t.sample        = value;
      t.query_channel = ChanWidth'($urandom_range(0, 31));
      stimulus_q.push_back(t);
   endtask

   task automatic add_read(input logic [ChanWidth-1:0] code);
      req_payload_type t;
      t.kind          = KindRead;
      t.sample        = SampleWidth'($urandom_range(0, 4095));
      t.query_channel = code;
      stimulus_q.push_back(t);
   endtask

   // driver: a transaction stays on the bus until it is taken
   always @(negedge clock) begin : drive_req
      req_payload_type t;
      if (!reset && (!req_bus.valid || req_taken)) begin
         if (stimulus_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
            t = stimulus_q.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.kind          <= t.kind;
            req_bus.sample        <= t.sample;
            req_bus.query_channel <= t.query_channel;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with one long hold-off while the sender runs flat out
   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_count >= 550) begin
            hold_left = 40;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
         end
      end
   end

   // monitor: check responses against the oldest prediction, then predict new ones
   always @(posedge clock) begin : watch_bus
      req_payload_type t;
      rsp_payload_type want;
      req_taken <= req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_avg_q.size() == 0) begin
               report_mismatch("response with no transaction outstanding");
            end else begin
               want = expected_avg_q.pop_front();
               if (rsp_bus.next_slot !== want.next_slot)
                  report_mismatch($sformatf("next_slot got %0d want %0d",
                                            rsp_bus.next_slot, want.next_slot));
               if (rsp_bus.window_done !== want.window_done)
                  report_mismatch($sformatf("window_done got %0d want %0d",
                                            rsp_bus.window_done, want.window_done));
               if (rsp_bus.done_slot !== want.done_slot)
                  report_mismatch($sformatf("done_slot got %0d want %0d",
                                            rsp_bus.done_slot, want.done_slot));
               if (rsp_bus.done_average !== want.done_average)
                  report_mismatch($sformatf("done_average got %0d want %0d",
                                            rsp_bus.done_average, want.done_average));
               if (rsp_bus.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value got %0d want %0d",
                                            rsp_bus.read_value, want.read_value));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            t.kind          = req_bus.kind;
            t.sample        = req_bus.sample;
            t.query_channel = req_bus.query_channel;
            expected_avg_q.push_back(trimmed_mean_step(t));
            accepted_count++;
         end
      end
   end

   initial begin : main_seq
      logic [SampleWidth-1:0] prev;
      logic [ChanWidth-1:0]   known[3];
      req_bus.valid         = 1'b0;
      req_bus.kind          = KindSample;
      req_bus.sample        = '0;
      req_bus.query_channel = '0;
      rsp_bus.ready         = 1'b0;
      reset                 = 1'b1;

      slot_now  = '0;
      win_count = '0;
      win_max   = '0;
      win_min   = SampleMax;
      win_sum   = '0;
      foreach (slot_avg[i]) slot_avg[i] = '0;

      known[0] = ChanSlot0;
      known[1] = ChanSlot1;
      known[2] = ChanSlot2;

      // slot 0: extremes mixed, min and max both repeated
      add_sample(12'd0);
      add_sample(SampleMax);
      add_sample(SampleMax);
      add_sample(SampleMax);
      add_sample(12'd0);
      add_sample(12'd0);
      // slot 1: full scale window gives the largest average
      repeat (6) add_sample(SampleMax);
      // slot 2: small values with a read in the middle of the window
      add_sample(12'd1);
      add_sample(12'd2);
      add_read(ChanSlot2);
      add_sample(12'd3);
      add_sample(12'd4);
      add_sample(12'd5);
      add_sample(12'd6);
      // known codes, then unknown ones
      add_read(ChanSlot0);
      add_read(ChanSlot1);
      add_read(ChanSlot2);
      add_read(5'd0);
      add_read(5'd31);
      add_read(5'd13);

      prev = '0;
      repeat (725) begin
         if ($urandom_range(0, 99) < 78) begin
            case ($urandom_range(0, 9))
               0:       prev = '0;
               1:       prev = SampleMax;
               2:       prev = prev;
               default: prev = SampleWidth'($urandom_range(0, 4095));
            endcase
            add_sample(prev);
         end else if ($urandom_range(0, 99) < 60) begin
            add_read(known[2'($urandom_range(0, 2))]);
         end else begin
            add_read(ChanWidth'($urandom_range(0, 31)));
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stimulus_q.size() != 0 || req_bus.valid || expected_avg_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> files.f
rtl/core/trm_pkg.sv
rtl/core/trm_if.sv
rtl/core/trm_window.sv
rtl/core/round_robin_trimmed_mean_adc.sv
rtl/core/trm_checker.sv
tb/tb_top.sv
